### hdl/dpnc_pkg.sv
// ----------------------------------------------------------------------------
// dpnc_pkg
// Shared constants and name tables for the digest parameter name classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package dpnc_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int POS_W      = $clog2(MAX_LEN + 1);
    localparam int NAME_COUNT = 10;
    localparam int NAME_DEPTH = 9;
    localparam int OFFSET_W   = 10;
    localparam int TYPE_W     = 4;
    // param_type, equals_offset, parse_ok, padded to whole bytes
    localparam int OUT_W      = 16;

    localparam logic [TYPE_W-1:0] TYPE_USERNAME  = 4'd0;
    localparam logic [TYPE_W-1:0] TYPE_REALM     = 4'd1;
    localparam logic [TYPE_W-1:0] TYPE_NONCE     = 4'd2;
    localparam logic [TYPE_W-1:0] TYPE_URI       = 4'd3;
    localparam logic [TYPE_W-1:0] TYPE_RESPONSE  = 4'd4;
    localparam logic [TYPE_W-1:0] TYPE_CNONCE    = 4'd5;
    localparam logic [TYPE_W-1:0] TYPE_OPAQUE    = 4'd6;
    localparam logic [TYPE_W-1:0] TYPE_QOP       = 4'd7;
    localparam logic [TYPE_W-1:0] TYPE_NC        = 4'd8;
    localparam logic [TYPE_W-1:0] TYPE_ALGORITHM = 4'd9;
    localparam logic [TYPE_W-1:0] TYPE_OTHER     = 4'd10;
    localparam logic [TYPE_W-1:0] NO_MATCH       = 4'd15;

    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    // names in lower case, indexed by type code
    localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_DEPTH] = '{
        '{"u", "s", "e", "r", "n", "a", "m", "e", 8'h00},
        '{"r", "e", "a", "l", "m", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "o", "n", "c", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "r", "i", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "s", "p", "o", "n", "s", "e", 8'h00},
        '{"c", "n", "o", "n", "c", "e", 8'h00, 8'h00, 8'h00},
        '{"o", "p", "a", "q", "u", "e", 8'h00, 8'h00, 8'h00},
        '{"q", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "c", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "l", "g", "o", "r", "i", "t", "h", "m"}
    };

    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
        4'd8, 4'd5, 4'd5, 4'd3, 4'd8, 4'd6, 4'd6, 4'd3, 4'd2, 4'd9
    };

endpackage

`default_nettype wire

### hdl/digest_param_name_classifier_unit.sv
// ----------------------------------------------------------------------------
// digest_param_name_classifier_unit
// Classifies the name of a digest parameter from its bytes, one per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one text byte per beat in s_tdata, with s_tlast on
//   the final byte of the parameter text. On the beat carrying s_tlast the
//   block produces one result beat on the master side: the name type, the
//   offset of the first '=' and a parse-ok flag. Other beats give no result.
//   The result register loads at the edge that takes the last byte.
//   Throughput is one byte per cycle while no result is stalled; the
//   per-byte work is a ten-way compare against the name table and a
//   candidate mask update. A new byte is taken while a result waits, as
//   long as that wait ends in the same cycle (s_tready = !m_tvalid ||
//   m_tready). While the receiver stalls with a result pending, s_tready
//   is low and all state holds. Reset clears the match state to the start
//   of a text and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module digest_param_name_classifier_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] data_byte
    input  wire logic                     s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [3:0] param_type, [13:4] equals_offset, [14] parse_ok, [15] zero
    output logic [dpnc_pkg::OUT_W-1:0]    m_tdata
);
    import dpnc_pkg::*;

    logic [POS_W-1:0]      byte_pos_reg,   byte_pos_next;
    logic [NAME_COUNT-1:0] live_reg,       live_next;
    logic [TYPE_W-1:0]     matched_reg,    matched_next;
    logic                  gap_ws_reg,     gap_ws_next;
    logic                  eq_seen_reg,    eq_seen_next;
    logic [OFFSET_W-1:0]   eq_pos_reg,     eq_pos_next;
    logic [TYPE_W-1:0]     chosen_reg,     chosen_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [OUT_W-1:0]      out_data_reg,   out_data_next;

    logic                  accept;
    logic                  active;
    logic                  is_eq;
    logic                  is_ws;
    logic [7:0]            folded;
    logic [NAME_COUNT-1:0] in_name;
    logic [NAME_COUNT-1:0] hit;
    logic [NAME_COUNT-1:0] done;
    logic [TYPE_W-1:0]     first_done;
    logic [TYPE_W-1:0]     res_type;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign active = !eq_seen_reg && (byte_pos_reg < POS_W'(MAX_LEN));
    assign is_eq  = (s_tdata == CHAR_EQUALS);
    assign is_ws  = (s_tdata == 8'h20) || (s_tdata == 8'h09) ||
                    (s_tdata == 8'h0D) || (s_tdata == 8'h0A);
    assign folded = s_tdata | CASE_BIT;

    always_comb
    begin
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            in_name[i] = live_reg[i] && (byte_pos_reg < POS_W'(NAME_LEN[i]));
            hit[i]     = in_name[i] && (folded == NAME_TEXT[i][byte_pos_reg[3:0]]);
            done[i]    = hit[i] && (byte_pos_reg == POS_W'(NAME_LEN[i] - 4'd1));
        end
        // lowest index wins when two names end on the same byte
        first_done = NO_MATCH;
        for (int i = NAME_COUNT - 1; i >= 0; i--)
        begin
            if (done[i])
            begin
                first_done = TYPE_W'(i);
            end
        end
    end

    always_comb
    begin
        live_next    = live_reg;
        matched_next = matched_reg;
        gap_ws_next  = gap_ws_reg;
        eq_seen_next = eq_seen_reg;
        eq_pos_next  = eq_pos_reg;
        chosen_next  = chosen_reg;

        if (active && is_eq)
        begin
            eq_seen_next = 1'b1;
            eq_pos_next  = OFFSET_W'(byte_pos_reg);
            chosen_next  = (matched_reg != NO_MATCH && gap_ws_reg) ? matched_reg
                                                                   : TYPE_OTHER;
        end
        else if (active)
        begin
            if (matched_reg != NO_MATCH && !is_ws)
            begin
                gap_ws_next = 1'b0;
            end
            live_next = live_reg & ~(in_name & ~hit);
            if (matched_reg == NO_MATCH)
            begin
                matched_next = first_done;
            end
        end

        byte_pos_next = (byte_pos_reg < POS_W'(MAX_LEN)) ? byte_pos_reg + 1'b1
                                                         : byte_pos_reg;

        // result as it stands once this byte is counted
        res_type = (byte_pos_next < POS_W'(4)) ? TYPE_OTHER : chosen_next;
        if (eq_seen_next)
        begin
            out_data_next = {1'b0, 1'b1, eq_pos_next, res_type};
        end
        else
        begin
            out_data_next = {1'b0, 1'b0, OFFSET_W'(0), TYPE_OTHER};
        end

        if (accept && s_tlast)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg  <= '0;
            live_reg      <= '1;
            matched_reg   <= NO_MATCH;
            gap_ws_reg    <= 1'b1;
            eq_seen_reg   <= 1'b0;
            eq_pos_reg    <= '0;
            chosen_reg    <= TYPE_OTHER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept && s_tlast)
            begin
                // end of text: start afresh for the next one
                byte_pos_reg <= '0;
                live_reg     <= '1;
                matched_reg  <= NO_MATCH;
                gap_ws_reg   <= 1'b1;
                eq_seen_reg  <= 1'b0;
                eq_pos_reg   <= '0;
                chosen_reg   <= TYPE_OTHER;
            end
            else if (accept)
            begin
                byte_pos_reg <= byte_pos_next;
                live_reg     <= live_next;
                matched_reg  <= matched_next;
                gap_ws_reg   <= gap_ws_next;
                eq_seen_reg  <= eq_seen_next;
                eq_pos_reg   <= eq_pos_next;
                chosen_reg   <= chosen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

### hdl/dpnc_checker.sv
// ----------------------------------------------------------------------------
// dpnc_checker
// Port-level checks for the digest parameter name classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module dpnc_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic                     s_tlast,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [dpnc_pkg::OUT_W-1:0] m_tdata
);
    import dpnc_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // the last byte of a text always yields a result next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    // parse error carries type other and a zero offset
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[14] |-> m_tdata[13:4] == 10'd0 &&
                                     m_tdata[3:0] == TYPE_OTHER)
        else $error("parse error with non-default fields");

    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= TYPE_OTHER && !m_tdata[15])
        else $error("bad type code or pad bit");

    // no new beat taken while a result is stuck
    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

bind digest_param_name_classifier_unit dpnc_checker u_dpnc_checker (.*);

`default_nettype wire
